[hw/rtl/uvs_pkg.sv]
// ----------------------------------------------------------------------------
// UV-sphere generator package
// Shared types, constants and tables for the sphere vertex and index pipeline.
// ----------------------------------------------------------------------------
package uvs_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_RADIUS       = 2'd0;
  localparam logic [1:0] REG_SECTOR_COUNT = 2'd1;
  localparam logic [1:0] REG_STACK_COUNT  = 2'd2;

  localparam logic [15:0] RADIUS_RESET       = 16'd256;
  localparam logic [8:0]  SECTOR_COUNT_RESET = 9'd36;
  localparam logic [8:0]  STACK_COUNT_RESET  = 9'd18;

  localparam logic [8:0] MIN_SECTORS = 9'd3;
  localparam logic [8:0] MAX_SECTORS = 9'd256;
  localparam logic [8:0] MIN_STACKS  = 9'd2;
  localparam logic [8:0] MAX_STACKS  = 9'd256;

  // Divider: 17 quotient bits, one per cell.
  localparam int unsigned DIV_STEPS = 17;
  // CORDIC: 24 rotation cells.
  localparam int unsigned CORDIC_STEPS = 24;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [31:0] QUARTER_TURN = 32'sh4000_0000;
  localparam logic signed [22:0] COORD_LIMIT = 23'sd65535;

  typedef struct packed {
    logic [16:0] first;
    logic        quad_valid;
  } uvs_meta_t;

  // One restoring-division lane: partial remainder and a register that
  // shifts out numerator bits while shifting in quotient bits.
  typedef struct packed {
    logic [7:0]  rem;
    logic [16:0] nq;
  } div_lane_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic               flip;
  } crd_lane_t;

  // Arctangent of 2^-k as a fraction of a full turn, 32 bits per turn.
  function automatic logic signed [31:0] atan_turn(input logic [4:0] k);
    logic signed [31:0] a;
    unique case (k)
      5'd0:  a = 32'sd536870912;
      5'd1:  a = 32'sd316933406;
      5'd2:  a = 32'sd167458907;
      5'd3:  a = 32'sd85004756;
      5'd4:  a = 32'sd42667331;
      5'd5:  a = 32'sd21354465;
      5'd6:  a = 32'sd10679838;
      5'd7:  a = 32'sd5340245;
      5'd8:  a = 32'sd2670163;
      5'd9:  a = 32'sd1335087;
      5'd10: a = 32'sd667544;
      5'd11: a = 32'sd333772;
      5'd12: a = 32'sd166886;
      5'd13: a = 32'sd83443;
      5'd14: a = 32'sd41722;
      5'd15: a = 32'sd20861;
      5'd16: a = 32'sd10430;
      5'd17: a = 32'sd5215;
      5'd18: a = 32'sd2608;
      5'd19: a = 32'sd1304;
      5'd20: a = 32'sd652;
      5'd21: a = 32'sd326;
      5'd22: a = 32'sd163;
      5'd23: a = 32'sd81;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

  // Clip a coordinate to the symmetric Q8.8 range.
  function automatic logic signed [16:0] sat_coord(input logic signed [22:0] v);
    logic signed [16:0] r;
    if (v > COORD_LIMIT) begin
      r = 17'sd65535;
    end else if (v < -COORD_LIMIT) begin
      r = -17'sd65535;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/uvs_div_cell.sv]
// ----------------------------------------------------------------------------
// UV-sphere divider cell
// One restoring-division step for the sector and stack phase lanes.
// ----------------------------------------------------------------------------
module uvs_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [8:0]        sec_div_i,
  input  logic [8:0]        stk_div_i,
  input  uvs_pkg::div_lane_t sec_i,
  input  uvs_pkg::div_lane_t stk_i,
  input  uvs_pkg::uvs_meta_t meta_i,
  output logic              vld_o,
  output uvs_pkg::div_lane_t sec_o,
  output uvs_pkg::div_lane_t stk_o,
  output uvs_pkg::uvs_meta_t meta_o
);
  import uvs_pkg::*;

  function automatic div_lane_t div_step(input div_lane_t l, input logic [8:0] d);
    logic [8:0] r2;
    logic       ge;
    div_lane_t  o;
    r2 = {l.rem, l.nq[16]};
    ge = (r2 >= d);
    o.rem = ge ? 8'(r2 - d) : r2[7:0];
    o.nq  = {l.nq[15:0], ge};
    return o;
  endfunction

  logic vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec_o  <= div_step(sec_i, sec_div_i);
      stk_o  <= div_step(stk_i, stk_div_i);
      meta_o <= meta_i;
    end
  end

  assign vld_o = vld_q;

endmodule

[hw/rtl/uvs_cordic_cell.sv]
// ----------------------------------------------------------------------------
// UV-sphere CORDIC cell
// One rotation step applied to the stack and sector angle lanes.
// ----------------------------------------------------------------------------
module uvs_cordic_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [4:0]        step_i,
  input  logic              vld_i,
  input  uvs_pkg::crd_lane_t a_i,
  input  uvs_pkg::crd_lane_t b_i,
  input  uvs_pkg::uvs_meta_t meta_i,
  output logic              vld_o,
  output uvs_pkg::crd_lane_t a_o,
  output uvs_pkg::crd_lane_t b_o,
  output uvs_pkg::uvs_meta_t meta_o
);
  import uvs_pkg::*;

  function automatic crd_lane_t rotate(input crd_lane_t l, input logic [4:0] k);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] at;
    crd_lane_t          o;
    dx = $signed(l.y) >>> k;
    dy = $signed(l.x) >>> k;
    at = atan_turn(k);
    o.flip = l.flip;
    if (!l.z[31]) begin
      o.x = l.x - dx;
      o.y = l.y + dy;
      o.z = l.z - at;
    end else begin
      o.x = l.x + dx;
      o.y = l.y - dy;
      o.z = l.z + at;
    end
    return o;
  endfunction

  logic vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o    <= rotate(a_i, step_i);
      b_o    <= rotate(b_i, step_i);
      meta_o <= meta_i;
    end
  end

  assign vld_o = vld_q;

endmodule

[hw/rtl/uv_sphere_vertex_index_gen.sv]
// ----------------------------------------------------------------------------
// UV-sphere vertex and index generator
// Turns one sphere grid point into its Q8.8 vertex and two triangle indices.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel carries a stack index and a sector
// index. For every request the block returns exactly one result carrying the
// vertex position (pos_x, pos_y, pos_z, signed Q8.8) and, when a quad starts
// at that point, the six vertex indices of its two triangles.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. The block takes one request per cycle while in_stall_o is low
// and has 48 register stages: the entry register, a chain of 17 divider
// cells that produce the two phases, a fold stage, a chain of 24 CORDIC
// cells, four back-end stages (flip, multiply, round, multiply) and the
// output register.
// When the receiver stalls while a result is held in the output register, the
// whole chain freezes and in_stall_o rises in the same cycle; bubbles in the
// chain do not need a stall to drain, so an empty output register always lets
// the chain advance.
// Reset clears all valid bits and loads radius 1.0, 36 sectors, 18 stacks.
// Configuration writes take effect at once and must only be made while no
// request is in flight.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_index_gen (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [8:0]         stack_index_i,
  input  logic [8:0]         sector_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic               quad_valid_o,
  output logic [16:0]        tri_a0_o,
  output logic [16:0]        tri_a1_o,
  output logic [16:0]        tri_a2_o,
  output logic [16:0]        tri_b0_o,
  output logic [16:0]        tri_b1_o,
  output logic [16:0]        tri_b2_o
);
  import uvs_pkg::*;

  // Configuration registers.
  logic [15:0] radius_q;
  logic [8:0]  sector_count_q;
  logic [8:0]  stack_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q       <= RADIUS_RESET;
      sector_count_q <= SECTOR_COUNT_RESET;
      stack_count_q  <= STACK_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RADIUS:       radius_q       <= cfg_data_i;
        REG_SECTOR_COUNT: sector_count_q <= cfg_data_i[8:0];
        REG_STACK_COUNT:  stack_count_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Counts clamped to their legal range. The user must keep them stable while
  // requests are in flight, as the block does not enforce it; stages use them directly.
  logic [8:0] sc_c;
  logic [8:0] tc_c;

  always_comb begin
    if (sector_count_q < MIN_SECTORS) begin
      sc_c = MIN_SECTORS;
    end else if (sector_count_q > MAX_SECTORS) begin
      sc_c = MAX_SECTORS;
    end else begin
      sc_c = sector_count_q;
    end
    if (stack_count_q < MIN_STACKS) begin
      tc_c = MIN_STACKS;
    end else if (stack_count_q > MAX_STACKS) begin
      tc_c = MAX_STACKS;
    end else begin
      tc_c = stack_count_q;
    end
  end

  // The whole chain moves together unless a held result is stalled.
  logic out_vld_q;
  logic en;

  assign en          = !out_vld_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_vld_q;

  // Entry stage: clamp the grid point, build the two dividends and the index
  // of the quad's first vertex.
  logic [8:0]  i_c;
  logic [8:0]  j_c;
  logic [16:0] first_d;

  assign i_c     = (stack_index_i > tc_c) ? tc_c : stack_index_i;
  assign j_c     = (sector_index_i > sc_c) ? sc_c : sector_index_i;
  assign first_d = 17'(17'(i_c) * (17'(sc_c) + 17'd1)) + 17'(j_c);

  logic      div_vld [0:DIV_STEPS];
  div_lane_t div_sec [0:DIV_STEPS];
  div_lane_t div_stk [0:DIV_STEPS];
  uvs_meta_t div_meta [0:DIV_STEPS];
  logic      entry_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= 1'b0;
    end else if (en) begin
      entry_vld_q <= in_valid_i;
    end
  end

  // Sector dividend is j * 2^16 + sc / 2; stack dividend is i * 2^15 + tc / 2.
  // The top bits go straight into the remainder since they stay below the
  // divisor.
  always_ff @(posedge clk_i) begin
    if (en) begin
      div_sec[0].rem  <= j_c[8:1];
      div_sec[0].nq   <= {j_c[0], 16'd0} + 17'(sc_c[8:1]);
      div_stk[0].rem  <= {1'b0, i_c[8:2]};
      div_stk[0].nq   <= {i_c[1:0], 15'd0} + 17'(tc_c[8:1]);
      div_meta[0].first      <= first_d;
      div_meta[0].quad_valid <= (i_c < tc_c) && (j_c < sc_c);
    end
  end

  assign div_vld[0] = entry_vld_q;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    uvs_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .vld_i     (div_vld[g]),
      .sec_div_i (sc_c),
      .stk_div_i (tc_c),
      .sec_i     (div_sec[g]),
      .stk_i     (div_stk[g]),
      .meta_i    (div_meta[g]),
      .vld_o     (div_vld[g+1]),
      .sec_o     (div_sec[g+1]),
      .stk_o     (div_stk[g+1]),
      .meta_o    (div_meta[g+1])
    );
  end

  // Fold stage: turn the quotients into 32-bit turn phases and fold them into
  // the right half plane, remembering a sign flip.
  logic [15:0]        ph_sec;
  logic [15:0]        ph_stk;
  logic signed [31:0] z_sec;
  logic signed [31:0] z_stk;
  crd_lane_t          fold_sec;
  crd_lane_t          fold_stk;

  assign ph_sec = div_sec[DIV_STEPS].nq[15:0];
  assign ph_stk = 16'h4000 - div_stk[DIV_STEPS].nq[15:0];
  assign z_sec  = {ph_sec, 16'd0};
  assign z_stk  = {ph_stk, 16'd0};

  function automatic crd_lane_t fold(input logic signed [31:0] z);
    crd_lane_t o;
    o.x = CORDIC_GAIN;
    o.y = 33'sd0;
    if (z > QUARTER_TURN || z < -QUARTER_TURN) begin
      // Half a turn away, which in 32-bit phase is a flip of the top bit.
      o.z    = {~z[31], z[30:0]};
      o.flip = 1'b1;
    end else begin
      o.z    = z;
      o.flip = 1'b0;
    end
    return o;
  endfunction

  assign fold_sec = fold(z_sec);
  assign fold_stk = fold(z_stk);

  logic      crd_vld [0:CORDIC_STEPS];
  crd_lane_t crd_a [0:CORDIC_STEPS];
  crd_lane_t crd_b [0:CORDIC_STEPS];
  uvs_meta_t crd_meta [0:CORDIC_STEPS];
  logic      fold_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_vld_q <= 1'b0;
    end else if (en) begin
      fold_vld_q <= div_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      crd_a[0]    <= fold_stk;
      crd_b[0]    <= fold_sec;
      crd_meta[0] <= div_meta[DIV_STEPS];
    end
  end

  assign crd_vld[0] = fold_vld_q;

  // Lane a carries the stack angle, lane b the sector angle.
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_crd
    uvs_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (5'(g)),
      .vld_i  (crd_vld[g]),
      .a_i    (crd_a[g]),
      .b_i    (crd_b[g]),
      .meta_i (crd_meta[g]),
      .vld_o  (crd_vld[g+1]),
      .a_o    (crd_a[g+1]),
      .b_o    (crd_b[g+1]),
      .meta_o (crd_meta[g+1])
    );
  end

  // Back end: undo the fold, then scale by the radius in two products with
  // half-up rounding after each.
  crd_lane_t crd_a_end;
  crd_lane_t crd_b_end;

  assign crd_a_end = crd_a[CORDIC_STEPS];
  assign crd_b_end = crd_b[CORDIC_STEPS];

  logic               e1_vld_q;
  logic               e2_vld_q;
  logic               e3_vld_q;
  logic               e4_vld_q;
  uvs_meta_t          e1_meta_q;
  uvs_meta_t          e2_meta_q;
  uvs_meta_t          e3_meta_q;
  uvs_meta_t          e4_meta_q;
  logic signed [32:0] ca_q;
  logic signed [32:0] sa_q;
  logic signed [32:0] cb_q;
  logic signed [32:0] sb_q;
  logic signed [32:0] cb2_q;
  logic signed [32:0] sb2_q;
  logic signed [32:0] cb3_q;
  logic signed [32:0] sb3_q;
  logic signed [49:0] prod_xy_q;
  logic signed [49:0] prod_z_q;
  logic signed [27:0] xy_q;
  logic signed [16:0] pz_q;
  logic signed [16:0] pz4_q;
  logic signed [60:0] prod_x_q;
  logic signed [60:0] prod_y_q;

  logic signed [49:0] xy_rnd;
  logic signed [49:0] z_rnd;
  logic signed [60:0] x_rnd;
  logic signed [60:0] y_rnd;

  assign xy_rnd = prod_xy_q + (50'sd1 <<< 21);
  assign z_rnd  = prod_z_q + (50'sd1 <<< 29);
  assign x_rnd  = prod_x_q + (61'sd1 <<< 37);
  assign y_rnd  = prod_y_q + (61'sd1 <<< 37);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q  <= 1'b0;
      e2_vld_q  <= 1'b0;
      e3_vld_q  <= 1'b0;
      e4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      e1_vld_q  <= crd_vld[CORDIC_STEPS];
      e2_vld_q  <= e1_vld_q;
      e3_vld_q  <= e2_vld_q;
      e4_vld_q  <= e3_vld_q;
      out_vld_q <= e4_vld_q;
    end
  end

  logic [16:0] second;

  assign second = e4_meta_q.first + 17'(sc_c) + 17'd1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Stage 1: apply the fold flip.
      ca_q      <= crd_a_end.flip ? -crd_a_end.x : crd_a_end.x;
      sa_q      <= crd_a_end.flip ? -crd_a_end.y : crd_a_end.y;
      cb_q      <= crd_b_end.flip ? -crd_b_end.x : crd_b_end.x;
      sb_q      <= crd_b_end.flip ? -crd_b_end.y : crd_b_end.y;
      e1_meta_q <= crd_meta[CORDIC_STEPS];
      // Stage 2: radius times cos and sin of the stack angle.
      prod_xy_q <= $signed({1'b0, radius_q}) * ca_q;
      prod_z_q  <= $signed({1'b0, radius_q}) * sa_q;
      cb2_q     <= cb_q;
      sb2_q     <= sb_q;
      e2_meta_q <= e1_meta_q;
      // Stage 3: round the ring radius and the height.
      xy_q      <= xy_rnd[49:22];
      pz_q      <= sat_coord(23'($signed(z_rnd[49:30])));
      cb3_q     <= cb2_q;
      sb3_q     <= sb2_q;
      e3_meta_q <= e2_meta_q;
      // Stage 4: ring radius times cos and sin of the sector angle.
      prod_x_q  <= xy_q * cb3_q;
      prod_y_q  <= xy_q * sb3_q;
      pz4_q     <= pz_q;
      e4_meta_q <= e3_meta_q;
      // Output register.
      pos_x_o      <= sat_coord(x_rnd[60:38]);
      pos_y_o      <= sat_coord(y_rnd[60:38]);
      pos_z_o      <= pz4_q;
      quad_valid_o <= e4_meta_q.quad_valid;
      if (e4_meta_q.quad_valid) begin
        tri_a0_o <= e4_meta_q.first;
        tri_a1_o <= second;
        tri_a2_o <= e4_meta_q.first + 17'd1;
        tri_b0_o <= second;
        tri_b1_o <= second + 17'd1;
        tri_b2_o <= e4_meta_q.first + 17'd1;
      end else begin
        tri_a0_o <= 17'd0;
        tri_a1_o <= 17'd0;
        tri_a2_o <= 17'd0;
        tri_b0_o <= 17'd0;
        tri_b1_o <= 17'd0;
        tri_b2_o <= 17'd0;
      end
    end
  end

endmodule
